>>> hdl/tvmd_pkg.sv
// ----------------------------------------------------------------------------
// tvmd_pkg
// Shared constants and CORDIC angle table for the torus diffusion step.
// ----------------------------------------------------------------------------
package tvmd_pkg;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int NSTAGES = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [28:0] INV_PI_Q30 = 29'd341782638;
  localparam logic [24:0] STEP_ONE = 25'd16777216;
  localparam logic [24:0] STEP_RESET = 25'd167772;
  localparam int CFG_WIDTH = 32;

  typedef enum logic [2:0] {
    REG_MEAN_1 = 3'd0,
    REG_MEAN_2 = 3'd1,
    REG_PULL_1 = 3'd2,
    REG_PULL_2 = 3'd3,
    REG_COUP_1 = 3'd4,
    REG_COUP_2 = 3'd5,
    REG_STEP   = 3'd6
  } cfg_reg_t;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933405;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335086;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41721;
      15: r = 34'sd20860;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2607;      19: r = 34'sd1303;      20: r = 34'sd651;
      21: r = 34'sd325;       22: r = 34'sd162;       23: r = 34'sd81;
      24: r = 34'sd40;        25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;         28: r = 34'sd2;         29: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction
endpackage

>>> hdl/tvmd_if.sv
// ----------------------------------------------------------------------------
// tvmd_in_if / tvmd_out_if
// Valid/ready channels for input points and stepped points.
// ----------------------------------------------------------------------------
interface tvmd_in_if #(parameter int ANGLE_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [ANGLE_WIDTH-1:0] angle_1;
  logic signed [ANGLE_WIDTH-1:0] angle_2;
  logic signed [ANGLE_WIDTH-1:0] noise_1;
  logic signed [ANGLE_WIDTH-1:0] noise_2;
  modport source (output valid, angle_1, angle_2, noise_1, noise_2, input ready);
  modport sink (input valid, angle_1, angle_2, noise_1, noise_2, output ready);
endinterface

interface tvmd_out_if #(parameter int ANGLE_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [ANGLE_WIDTH-1:0] next_angle_1;
  logic signed [ANGLE_WIDTH-1:0] next_angle_2;
  modport source (output valid, next_angle_1, next_angle_2, input ready);
  modport sink (input valid, next_angle_1, next_angle_2, output ready);
endinterface

>>> hdl/torus_von_mises_diffusion_euler_step.sv
// ----------------------------------------------------------------------------
// torus_von_mises_diffusion_euler_step
// One Euler-Maruyama step of the bivariate von Mises diffusion on the torus.
//
// channel  dir  payload
// in_ch    in   angle_1, angle_2, noise_1, noise_2
// out_ch   out  next_angle_1, next_angle_2
// cfg      in   cfg_we, cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; pipeline stages: phase,
// 30 CORDIC stages, rounding, product, coefficient multiply, drift rounding,
// gain multiply, increment, add. The CORDIC pipeline sets the depth.
// Synchronous reset clears valid bits and restores register defaults.
// The whole pipeline advances only when the output stage is empty or taken.
// ----------------------------------------------------------------------------
module torus_von_mises_diffusion_euler_step
  import tvmd_pkg::*;
#(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  tvmd_in_if.sink              in_ch,
  tvmd_out_if.source           out_ch
);
  localparam int AW = ANGLE_WIDTH;
  localparam int NS = NSTAGES;
  localparam int DEPTH = NS + 8;
  localparam int SH = 47 - AW;

  logic [AW-1:0] mean_1, mean_2;
  logic signed [31:0] pull_1, pull_2, coup_1, coup_2;
  logic [24:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_1 <= '0; mean_2 <= '0; pull_1 <= '0; pull_2 <= '0;
      coup_1 <= '0; coup_2 <= '0; step <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEAN_1: mean_1 <= cfg_data[AW-1:0];
        REG_MEAN_2: mean_2 <= cfg_data[AW-1:0];
        REG_PULL_1: pull_1 <= cfg_data;
        REG_PULL_2: pull_2 <= cfg_data;
        REG_COUP_1: coup_1 <= cfg_data;
        REG_COUP_2: coup_2 <= cfg_data;
        REG_STEP:   step <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic [DEPTH-1:0] vld;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld[DEPTH-1];

  // step gain, recomputed every cycle from the clamped step register
  logic [24:0] stp;
  logic [53:0] gprod;
  logic signed [30:0] g;
  assign stp = (step > STEP_ONE) ? STEP_ONE : step;
  always_ff @(posedge clk) begin
    gprod <= 54'(stp) * 54'(INV_PI_Q30) + (54'd1 << 23);
    g <= 31'(gprod >> 24);
  end

  // angle / noise delay lines
  logic [AW-1:0] xa1 [DEPTH-1], xa2 [DEPTH-1], na1 [DEPTH-1], na2 [DEPTH-1];
  // CORDIC stages: two channels
  logic signed [33:0] cx [2][NS+1];
  logic signed [33:0] cy [2][NS+1];
  logic signed [33:0] cz [2][NS+1];
  logic               cf [2][NS+1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[DEPTH-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xa1[0] <= in_ch.angle_1; xa2[0] <= in_ch.angle_2;
      na1[0] <= in_ch.noise_1; na2[0] <= in_ch.noise_2;
      for (int k = 1; k < DEPTH-1; k++) begin
        xa1[k] <= xa1[k-1]; xa2[k] <= xa2[k-1];
        na1[k] <= na1[k-1]; na2[k] <= na2[k-1];
      end
    end
  end

  // stage 0: phase and quadrant fold
  logic signed [33:0] ph [2];
  always_comb begin
    logic [AW-1:0] d1, d2;
    d1 = in_ch.angle_1 - mean_1;
    d2 = in_ch.angle_2 - mean_2;
    ph[0] = 34'(signed'({d1, {(32-AW){1'b0}}}));
    ph[1] = 34'(signed'({d2, {(32-AW){1'b0}}}));
  end
  for (genvar c = 0; c < 2; c++) begin : g_fold
    always_ff @(posedge clk) begin
      if (adv) begin
        cx[c][0] <= CORDIC_GAIN;
        cy[c][0] <= '0;
        if (ph[c] > (34'sd1 <<< 30)) begin
          cz[c][0] <= ph[c] - (34'sd1 <<< 31); cf[c][0] <= 1'b1;
        end else if (ph[c] < -(34'sd1 <<< 30)) begin
          cz[c][0] <= ph[c] + (34'sd1 <<< 31); cf[c][0] <= 1'b1;
        end else begin
          cz[c][0] <= ph[c]; cf[c][0] <= 1'b0;
        end
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    for (genvar c = 0; c < 2; c++) begin : g_ch
      always_ff @(posedge clk) begin
        if (adv) begin
          cf[c][i+1] <= cf[c][i];
          if (cz[c][i] >= 0) begin
            cx[c][i+1] <= cx[c][i] - (cy[c][i] >>> i);
            cy[c][i+1] <= cy[c][i] + (cx[c][i] >>> i);
            cz[c][i+1] <= cz[c][i] - atan_turn(i);
          end else begin
            cx[c][i+1] <= cx[c][i] + (cy[c][i] >>> i);
            cy[c][i+1] <= cy[c][i] - (cx[c][i] >>> i);
            cz[c][i+1] <= cz[c][i] + atan_turn(i);
          end
        end
      end
    end
  end

  function automatic logic signed [17:0] clamp15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32768) r = 34'sd32768;
    if (r < -34'sd32768) r = -34'sd32768;
    return 18'(r);
  endfunction

  // rounding stage: sin/cos in Q.15
  logic signed [17:0] s1, c1, s2, c2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= clamp15(cf[0][NS] ? -cy[0][NS] : cy[0][NS]);
      c1 <= clamp15(cf[0][NS] ? -cx[0][NS] : cx[0][NS]);
      s2 <= clamp15(cf[1][NS] ? -cy[1][NS] : cy[1][NS]);
      c2 <= clamp15(cf[1][NS] ? -cx[1][NS] : cx[1][NS]);
    end
  end

  // product sc and hold s
  logic signed [35:0] p12, p21;
  logic signed [17:0] s1d, s2d;
  always_ff @(posedge clk) begin
    if (adv) begin
      p12 <= s2 * c1; p21 <= s1 * c2; s1d <= s1; s2d <= s2;
    end
  end
  logic signed [21:0] sc12, sc21;
  assign sc12 = 22'((p12 + 36'sd16384) >>> 15);
  assign sc21 = 22'((p21 + 36'sd16384) >>> 15);

  // coefficient products
  logic signed [53:0] ta1, ta2, tk1, tk2;
  always_ff @(posedge clk) begin
    if (adv) begin
      ta1 <= 54'(pull_1) * 54'(s1d); tk1 <= 54'(coup_1) * 54'(sc12);
      ta2 <= 54'(pull_2) * 54'(s2d); tk2 <= 54'(coup_2) * 54'(sc21);
    end
  end

  // drift rounded to Q.16
  logic signed [39:0] dd1, dd2;
  always_ff @(posedge clk) begin
    if (adv) begin
      dd1 <= 40'((tk1 - ta1 + 54'sd16384) >>> 15);
      dd2 <= 40'((tk2 - ta2 + 54'sd16384) >>> 15);
    end
  end

  // drift times gain
  logic signed [71:0] m1, m2;
  always_ff @(posedge clk) begin
    if (adv) begin
      m1 <= 72'(dd1) * 72'(g);
      m2 <= 72'(dd2) * 72'(g);
    end
  end

  logic [AW-1:0] inc1, inc2;
  always_ff @(posedge clk) begin
    if (adv) begin
      inc1 <= AW'((m1 + (72'sd1 <<< (SH-1))) >>> SH);
      inc2 <= AW'((m2 + (72'sd1 <<< (SH-1))) >>> SH);
    end
  end

  logic [AW-1:0] o1, o2;
  always_ff @(posedge clk) begin
    if (adv) begin
      o1 <= xa1[DEPTH-2] + inc1 + na1[DEPTH-2];
      o2 <= xa2[DEPTH-2] + inc2 + na2[DEPTH-2];
    end
  end
  assign out_ch.next_angle_1 = o1;
  assign out_ch.next_angle_2 = o2;
endmodule

>>> hdl/tvmd_checker.sv
// ----------------------------------------------------------------------------
// tvmd_checker
// Port-level checks for the diffusion step block.
// ----------------------------------------------------------------------------
module tvmd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] o1
);
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready) else $error("ready while stalled");
  a_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("not ready while empty");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(o1)) else $error("output lost");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind torus_von_mises_diffusion_euler_step tvmd_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .o1(out_ch.next_angle_1[15:0])
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the torus diffusion Euler step against a built-in fixed-point
// predictor: CORDIC sin/cos, drift products, step scaling and wrapping.
// Directed and random items over several register settings and idle phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import tvmd_pkg::*;

  localparam int AW = 16;

  typedef struct packed {
    logic [AW-1:0] a1;
    logic [AW-1:0] a2;
    logic [AW-1:0] n1;
    logic [AW-1:0] n2;
  } point_t;

  typedef struct packed {
    logic [AW-1:0] r1;
    logic [AW-1:0] r2;
  } stepped_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  tvmd_in_if #(.ANGLE_WIDTH(AW)) in_ch ();
  tvmd_out_if #(.ANGLE_WIDTH(AW)) out_ch ();

  torus_von_mises_diffusion_euler_step #(.ANGLE_WIDTH(AW)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [AW-1:0] mean_1, mean_2;
  logic signed [31:0] pull_1, pull_2, coup_1, coup_2;
  logic [24:0] step_reg;

  point_t pending_points[$];
  stepped_t expected_steps[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit send_hold = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp15(longint v);
    longint r;
    r = rnd(v, 15);
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void sin_cos(input logic [AW-1:0] ph, output longint sn,
                                  output longint cs);
    logic [31:0] p;
    longint z, x, y, xs, ys;
    bit flip;
    p = {ph, {(32 - AW){1'b0}}};
    z = longint'($signed(p));
    x = CORDIC_GAIN;
    y = 0;
    flip = 0;
    if (z > (longint'(1) << 30)) begin
      z -= longint'(1) << 31;
      flip = 1;
    end else if (z < -(longint'(1) << 30)) begin
      z += longint'(1) << 31;
      flip = 1;
    end
    for (int i = 0; i < NSTAGES; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_turn(i);
      end else begin
        x += ys; y -= xs; z += atan_turn(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = clamp15(y);
    cs = clamp15(x);
  endfunction

  function automatic stepped_t euler_step(point_t p);
    longint s1, c1, s2, c2, d1, d2, g, stp, inc1, inc2;
    stepped_t r;
    stp = (step_reg > STEP_ONE) ? longint'(STEP_ONE) : longint'(step_reg);
    sin_cos(p.a1 - mean_1, s1, c1);
    sin_cos(p.a2 - mean_2, s2, c2);
    d1 = -longint'(pull_1) * s1 + longint'(coup_1) * rnd(s2 * c1, 15);
    d2 = -longint'(pull_2) * s2 + longint'(coup_2) * rnd(s1 * c2, 15);
    g = rnd(stp * longint'(INV_PI_Q30), 24);
    inc1 = rnd(rnd(d1, 15) * g, 47 - AW);
    inc2 = rnd(rnd(d2, 15) * g, 47 - AW);
    r.r1 = p.a1 + inc1[AW-1:0] + p.n1;
    r.r2 = p.a2 + inc2[AW-1:0] + p.n2;
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MEAN_1: mean_1 = val[AW-1:0];
      REG_MEAN_2: mean_2 = val[AW-1:0];
      REG_PULL_1: pull_1 = val;
      REG_PULL_2: pull_2 = val;
      REG_COUP_1: coup_1 = val;
      REG_COUP_2: coup_2 = val;
      REG_STEP:   step_reg = val[24:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || expected_steps.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  task automatic random_config(int sel);
    write_reg(REG_MEAN_1, $urandom());
    write_reg(REG_MEAN_2, $urandom());
    write_reg(REG_PULL_1, rand_coef());
    write_reg(REG_PULL_2, rand_coef());
    write_reg(REG_COUP_1, rand_coef());
    write_reg(REG_COUP_2, rand_coef());
    case (sel)
      0: write_reg(REG_STEP, 32'd0);
      1: write_reg(REG_STEP, 32'(STEP_ONE));
      2: write_reg(REG_STEP, 32'h1ffffff);
      default: write_reg(REG_STEP, $urandom_range(0, 32'h1ffffff));
    endcase
  endtask

  function automatic logic [AW-1:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return AW'(32'h4000 + $urandom_range(0, 2) - 1);
      3: return AW'(32'hc000 + $urandom_range(0, 2) - 1);
      default: return AW'($urandom());
    endcase
  endfunction

  task automatic queue_random(int count);
    point_t p;
    for (int i = 0; i < count; i++) begin
      p.a1 = rand_angle();
      p.a2 = rand_angle();
      p.n1 = AW'($urandom());
      p.n2 = AW'($urandom());
      pending_points.push_back(p);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_points.size() != 0 && !send_hold &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        expected_steps.push_back(euler_step(p));
        in_ch.valid <= 1'b1;
        in_ch.angle_1 <= p.a1;
        in_ch.angle_2 <= p.a2;
        in_ch.noise_1 <= p.n1;
        in_ch.noise_2 <= p.n2;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // in_ch.ready is sampled at posedge; the item popped above is held until taken
  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected item %h %h", $time, out_ch.next_angle_1,
                 out_ch.next_angle_2);
        errors++;
      end else begin
        stepped_t e;
        e = expected_steps.pop_front();
        if (out_ch.next_angle_1 !== e.r1) begin
          $display("%0t: next_angle_1 expected %h actual %h", $time, e.r1,
                   out_ch.next_angle_1);
          errors++;
        end
        if (out_ch.next_angle_2 !== e.r2) begin
          $display("%0t: next_angle_2 expected %h actual %h", $time, e.r2,
                   out_ch.next_angle_2);
          errors++;
        end
      end
    end
  end

  initial begin
    point_t p;
    in_ch.valid = 1'b0;
    in_ch.angle_1 = '0;
    in_ch.angle_2 = '0;
    in_ch.noise_1 = '0;
    in_ch.noise_2 = '0;
    out_ch.ready = 1'b0;
    mean_1 = '0; mean_2 = '0;
    pull_1 = '0; pull_2 = '0; coup_1 = '0; coup_2 = '0;
    step_reg = STEP_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: zero drift, noise only
    p = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
    pending_points.push_back(p);
    drain();

    write_reg(REG_PULL_1, 32'h7fffffff);
    write_reg(REG_PULL_2, 32'h80000000);
    write_reg(REG_COUP_1, 32'h80000000);
    write_reg(REG_COUP_2, 32'h7fffffff);
    write_reg(REG_STEP, 32'(STEP_ONE));
    write_reg(REG_MEAN_1, 32'h8000);
    write_reg(REG_MEAN_2, 32'h7fff);
    pending_points.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    pending_points.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
    pending_points.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    pending_points.push_back('{16'hffff, 16'h0001, 16'hffff, 16'h0001});
    pending_points.push_back('{16'h4000, 16'hc000, 16'h0000, 16'h0000});
    pending_points.push_back('{16'hc000, 16'h4000, 16'h5555, 16'haaaa});
    pending_points.push_back('{16'h4001, 16'hbfff, 16'h1234, 16'hedcb});
    pending_points.push_back('{16'h3fff, 16'hc001, 16'h0000, 16'hffff});
    pending_points.push_back('{16'h2000, 16'he000, 16'h7fff, 16'h8000});
    drain();
    write_reg(REG_STEP, 32'h1ffffff);
    queue_random(8);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 64; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 64; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      queue_random(80);
      if (ph == 3) begin
        while (pending_points.size() > 40) @(posedge clk);
        send_hold = 1'b1;
        while (expected_steps.size() != 0) @(posedge clk);
        send_hold = 1'b0;
      end
      queue_random(80);
      drain();
    end

    if (errors == 0)
      $display("PASS torus_von_mises_diffusion_euler_step");
    else
      $display("FAIL torus_von_mises_diffusion_euler_step");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL torus_von_mises_diffusion_euler_step");
    $finish;
  end
endmodule

>>> torus_von_mises_diffusion_euler_step.f
hdl/tvmd_pkg.sv
hdl/tvmd_if.sv
hdl/torus_von_mises_diffusion_euler_step.sv
hdl/tvmd_checker.sv
bench/tb_top.sv
